// File: sv/hbs_pkg.sv
`default_nettype none

package hbs_pkg;

    localparam int HEIGHT_W   = 16;
    localparam int CELL_W     = 7;
    localparam int QUERY_W    = 24;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = QUERY_W + FRAC_W;

    // input tdata layout, lowest bit first
    localparam int OFS_CELL_X = 0;
    localparam int OFS_CELL_Z = OFS_CELL_X + CELL_W;
    localparam int OFS_HEIGHT = OFS_CELL_Z + CELL_W;
    localparam int OFS_QX     = OFS_HEIGHT + HEIGHT_W;
    localparam int OFS_QZ     = OFS_QX + QUERY_W;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = HEIGHT_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE  = 2'd2;

    localparam logic MODE_WRITE = 1'b0;

    typedef logic signed [HEIGHT_W-1:0] t_height;

    typedef struct packed {
        logic    we;
        t_height wdata;
    } t_ram_req;

endpackage

`default_nettype wire

// File: sv/heightmap_bilinear_sampler_core.sv
// Height grid with bilinear sampling.
// Input stream (s_axis): tuser selects the kind of item, 0 stores a Q7.8
// height at (cell_x, cell_z), 1 samples the grid at a Q15.8 world position.
// Output stream (m_axis): exactly one transaction per input item, holding
// the interpolated height and an in-range flag (zero and 0 for writes and
// for samples that fail the bounds check).
// Config channel: i_cfg_index 0 grid_width, 1 grid_depth, 2 inverse_scale;
// always ready, write only while the block is idle.
// A write goes straight to the output register; a sample is scaled and
// bounds-checked, and one that fails goes there without reading the grid.
// An in-range sample reads its four corners from the single-port grid RAM
// one per cycle, then passes a row blend, a column blend and a rounding stage.
// One item is in flight at a time; a new item is taken while a finished
// result still waits in the output register.
// Reset: config returns to 128 / 128 / 256 and the grid RAM is zeroed by a
// sweep over all MAX_WIDTH*MAX_DEPTH entries (16384 by default), during which
// s_axis_tready stays low. If m_axis_tready is low while a result waits in the
// output register, the sequencer holds its next result until the register frees up.
`default_nettype none

module heightmap_bilinear_sampler_core #(
    parameter int MAX_WIDTH = 128,
    parameter int MAX_DEPTH = 128
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [6:0] cell_x, [13:7] cell_z, [29:14] height_in, [53:30] query_x,
    // [77:54] query_z, [79:78] zero
    input  wire logic [hbs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] mode
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [15:0] height_out
    output logic [hbs_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // [0] in_range
    output logic                                  m_axis_tuser,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [hbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [hbs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hbs_pkg::*;

    localparam int MEM_DEPTH = MAX_WIDTH * MAX_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int LIM_W     = 11;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_RDW  = 4'd4;
    localparam logic [3:0] ST_ROW  = 4'd5;
    localparam logic [3:0] ST_COL  = 4'd6;
    localparam logic [3:0] ST_RND  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    // ---------------- configuration ----------------
    logic [7:0]  r_grid_width;
    logic [7:0]  r_grid_depth;
    logic [15:0] r_inv_scale;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= 8'd128;
            r_grid_depth <= 8'd128;
            r_inv_scale  <= 16'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GRID_WIDTH: r_grid_width <= i_cfg_data[7:0];
                REG_GRID_DEPTH: r_grid_depth <= i_cfg_data[7:0];
                REG_INV_SCALE:  r_inv_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input fields ----------------
    logic [CELL_W-1:0]         in_cell_x;
    logic [CELL_W-1:0]         in_cell_z;
    t_height                   in_height;
    logic signed [QUERY_W-1:0] in_qx;
    logic signed [QUERY_W-1:0] in_qz;

    assign in_cell_x = s_axis_tdata[OFS_CELL_X +: CELL_W];
    assign in_cell_z = s_axis_tdata[OFS_CELL_Z +: CELL_W];
    assign in_height = s_axis_tdata[OFS_HEIGHT +: HEIGHT_W];
    assign in_qx     = s_axis_tdata[OFS_QX +: QUERY_W];
    assign in_qz     = s_axis_tdata[OFS_QZ +: QUERY_W];

    // ---------------- sequencer registers ----------------
    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic signed [QUERY_W-1:0] r_qx;
    logic signed [QUERY_W-1:0] r_qz;
    logic signed [PROD_W-1:0]  r_px;
    logic signed [PROD_W-1:0]  r_pz;
    logic signed [8:0]         r_x0;
    logic signed [8:0]         r_z0;
    logic [FRAC_W-1:0]         r_fx;
    logic [FRAC_W-1:0]         r_fz;
    logic [1:0]                r_rd_k;
    logic                      r_cap_vld;
    logic [1:0]                r_cap_k;
    logic                      r_cap_ok;
    t_height                   r_h [4];
    logic signed [32:0]        r_r0;
    logic signed [32:0]        r_r1;
    logic signed [48:0]        r_acc;
    t_height                   r_res_h;
    logic                      r_res_rng;
    logic                      r_m_valid;
    t_height                   r_m_data;
    logic                      r_m_user;

    logic     ram_busy;
    t_height  ram_rdata;
    t_ram_req ram_req;
    logic [ADDR_W-1:0] ram_addr;

    logic s_acc;
    logic is_write;
    logic cell_ok;
    logic out_load;
    logic [ADDR_W-1:0] wr_addr;

    assign s_axis_tready = (r_state == ST_IDLE) && !ram_busy;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign is_write      = (s_axis_tuser == MODE_WRITE);
    assign out_load      = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);

    assign cell_ok = (LIM_W'(in_cell_x) < LIM_W'(MAX_WIDTH)) &&
                     (LIM_W'(in_cell_z) < LIM_W'(MAX_DEPTH));
    assign wr_addr = ADDR_W'(32'(in_cell_z) * MAX_WIDTH + 32'(in_cell_x));

    // ---------------- position scaling and bounds ----------------
    logic signed [PROD_W-1:0] mul_x;
    logic signed [PROD_W-1:0] mul_z;
    logic                     pass_x;
    logic                     pass_z;

    assign mul_x = r_qx * $signed({1'b0, r_inv_scale});
    assign mul_z = r_qz * $signed({1'b0, r_inv_scale});

    // truncated coordinate must lie in [0, size-1); values in (-1, 0) pass
    function automatic logic f_passes(input logic signed [PROD_W-1:0] p,
                                      input logic [7:0] size);
        logic               near_zero;
        logic [QUERY_W-1:0] t;
        near_zero = (&p[PROD_W-1:FRAC_W]) && (|p[FRAC_W-1:0]);
        t = p[PROD_W-1] ? '0 : p[PROD_W-1:FRAC_W];
        return (!p[PROD_W-1] || near_zero) && ((t + QUERY_W'(1)) < QUERY_W'(size));
    endfunction

    assign pass_x = f_passes(r_px, r_grid_width);
    assign pass_z = f_passes(r_pz, r_grid_depth);

    // ---------------- corner read ----------------
    logic signed [9:0] xc;
    logic signed [9:0] zc;
    logic              corner_ok;
    logic [ADDR_W-1:0] rd_addr;

    assign xc = {r_x0[8], r_x0} + {9'd0, r_rd_k[0]};
    assign zc = {r_z0[8], r_z0} + {9'd0, r_rd_k[1]};
    assign corner_ok = !xc[9] && !zc[9] &&
                       (xc[8:0] < {1'b0, r_grid_width}) &&
                       (zc[8:0] < {1'b0, r_grid_depth}) &&
                       (LIM_W'(xc[8:0]) < LIM_W'(MAX_WIDTH)) &&
                       (LIM_W'(zc[8:0]) < LIM_W'(MAX_DEPTH));
    assign rd_addr = ADDR_W'(32'(zc[8:0]) * MAX_WIDTH + 32'(xc[8:0]));

    assign ram_req.we    = s_acc && is_write && cell_ok;
    assign ram_req.wdata = in_height;
    assign ram_addr      = (r_state == ST_RD) ? rd_addr : wr_addr;

    hbs_grid_ram #(
        .DEPTH (MEM_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .i_addr  (ram_addr),
        .o_rdata (ram_rdata),
        .o_busy  (ram_busy)
    );

    // ---------------- blend ----------------
    logic signed [16:0] dh0;
    logic signed [16:0] dh1;
    logic signed [33:0] row0;
    logic signed [33:0] row1;
    logic signed [33:0] dr;
    logic signed [49:0] col;
    logic signed [49:0] rsum;
    logic signed [17:0] hq;
    t_height            h_sat;

    // h00*(1-fx) + h10*fx rewritten as h00 + (h10-h00)*fx
    assign dh0  = r_h[1] - r_h[0];
    assign dh1  = r_h[3] - r_h[2];
    assign row0 = $signed({{2{r_h[0][15]}}, r_h[0], 16'd0}) + dh0 * $signed({1'b0, r_fx});
    assign row1 = $signed({{2{r_h[2][15]}}, r_h[2], 16'd0}) + dh1 * $signed({1'b0, r_fx});

    assign dr  = r_r1 - r_r0;
    assign col = $signed({r_r0[32], r_r0, 16'd0}) + dr * $signed({1'b0, r_fz});

    // round half up at bit 32, then clamp to Q7.8
    assign rsum = r_acc + 50'sd2147483648;
    assign hq   = rsum[49:32];

    always_comb begin
        priority if (hq > 18'sd32767) begin
            h_sat = 16'sh7FFF;
        end else if (hq < -18'sd32768) begin
            h_sat = 16'sh8000;
        end else begin
            h_sat = hq[15:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_acc) n_state = is_write ? ST_OUT : ST_MUL;
            ST_MUL:  n_state = ST_CHK;
            ST_CHK:  n_state = (pass_x && pass_z) ? ST_RD : ST_OUT;
            ST_RD:   if (r_rd_k == 2'd3) n_state = ST_RDW;
            ST_RDW:  n_state = ST_ROW;
            ST_ROW:  n_state = ST_COL;
            ST_COL:  n_state = ST_RND;
            ST_RND:  n_state = ST_OUT;
            ST_OUT:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cap_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap_vld <= (r_state == ST_RD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_qx      <= in_qx;
            r_qz      <= in_qz;
            r_res_h   <= '0;
            r_res_rng <= 1'b0;
        end
        if (r_state == ST_MUL) begin
            r_px <= mul_x;
            r_pz <= mul_z;
        end
        if (r_state == ST_CHK) begin
            // floor corner; only meaningful when both checks pass
            r_x0   <= r_px[FRAC_W +: 9];
            r_z0   <= r_pz[FRAC_W +: 9];
            r_fx   <= r_px[FRAC_W-1:0];
            r_fz   <= r_pz[FRAC_W-1:0];
            r_rd_k <= 2'd0;
        end
        if (r_state == ST_RD) begin
            r_rd_k   <= r_rd_k + 2'd1;
            r_cap_k  <= r_rd_k;
            r_cap_ok <= corner_ok;
        end
        if (r_cap_vld) begin
            r_h[r_cap_k] <= r_cap_ok ? ram_rdata : '0;
        end
        if (r_state == ST_ROW) begin
            r_r0 <= row0[32:0];
            r_r1 <= row1[32:0];
        end
        if (r_state == ST_COL) begin
            r_acc <= col[48:0];
        end
        if (r_state == ST_RND) begin
            r_res_h   <= h_sat;
            r_res_rng <= 1'b1;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= r_res_h;
            r_m_user <= r_res_rng;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

`default_nettype wire

// File: sv/hbs_grid_ram.sv
`default_nettype none

module hbs_grid_ram #(
    parameter int DEPTH = 16384,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hbs_pkg::t_ram_req i_req,
    input  wire logic [ADDR_W-1:0] i_addr,
    output hbs_pkg::t_height       o_rdata,
    output logic                   o_busy
);
    import hbs_pkg::*;

    t_height           mem [DEPTH];
    t_height           r_rdata;
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // zeroing sweep after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // single port: a write or a read each cycle
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            mem[i_addr] <= i_req.wdata;
        end else begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

// File: sv/hbs_checker.sv
`default_nettype none

module hbs_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [hbs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input wire logic                             s_axis_tuser,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [hbs_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input wire logic                             m_axis_tuser,
    input wire logic                             i_cfg_valid,
    input wire logic                             o_cfg_ready,
    input wire logic [hbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input wire logic [hbs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hbs_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // writes and failed samples report zero height
    a_zero_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("nonzero height without in_range");

    // one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // grid clear sweep blocks input right after reset, no stale result
    a_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("block active right after reset");

endmodule

bind heightmap_bilinear_sampler_core hbs_checker u_hbs_checker (.*);

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top;

    import hbs_pkg::*;

    localparam int  GRID_MAX_W  = 128;
    localparam int  GRID_MAX_D  = 128;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  LONG_HOLD   = 400;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct {
        logic                       mode;
        logic [CELL_W-1:0]          cell_x;
        logic [CELL_W-1:0]          cell_z;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [QUERY_W-1:0]  qx;
        logic signed [QUERY_W-1:0]  qz;
    } t_grid_op;

    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic                in_range;
    } t_height_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    heightmap_bilinear_sampler_core #(
        .MAX_WIDTH(GRID_MAX_W),
        .MAX_DEPTH(GRID_MAX_D)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the grid and config
    logic signed [HEIGHT_W-1:0] grid_mirror [GRID_MAX_W*GRID_MAX_D];
    logic [7:0]  cfg_w   = 8'd128;
    logic [7:0]  cfg_d   = 8'd128;
    logic [15:0] cfg_inv = 16'd256;

    t_grid_op    op_q[$];
    t_height_res expected_heights[$];
    t_grid_op    cur_op;
    int          tx_gap_left = 0;
    int          rx_stall_left = 0;
    int          rx_hold_left = 0;
    int          hold_reqs = 0;
    int          holds_done = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    int          n_errors = 0;
    int          cyc_count = 0;
    logic        tx_valid_nxt;
    t_height_res res_tmp;
    t_height_res res_exp;

    function automatic int pick_gap(bit enable);
        int r;
        if (!enable)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint corner_height(longint x, longint z);
        if (x < 0 || z < 0)
            return 0;
        if (x >= longint'(cfg_w) || x >= GRID_MAX_W)
            return 0;
        if (z >= longint'(cfg_d) || z >= GRID_MAX_D)
            return 0;
        return longint'(grid_mirror[z*GRID_MAX_W + x]);
    endfunction

    function automatic bit on_grid(longint p, logic [7:0] size);
        longint t;
        if (p <= -65536)
            return 1'b0;
        t = (p >= 0) ? (p >>> 16) : 0;
        return t < longint'(size) - 1;
    endfunction

    // applies one transaction to the mirror, returns the height it should produce
    function automatic t_height_res apply_grid_op(t_grid_op op);
        t_height_res res;
        longint px, pz, x0, z0, fx, fz, r0, r1, acc, h;
        res.height   = '0;
        res.in_range = 1'b0;
        if (op.mode == MODE_WRITE) begin
            grid_mirror[int'(op.cell_z)*GRID_MAX_W + int'(op.cell_x)] = op.height;
            return res;
        end
        px = longint'(op.qx) * longint'(cfg_inv);
        pz = longint'(op.qz) * longint'(cfg_inv);
        if (!on_grid(px, cfg_w) || !on_grid(pz, cfg_d))
            return res;
        x0 = px >>> 16;
        z0 = pz >>> 16;
        fx = px & 65535;
        fz = pz & 65535;
        r0 = corner_height(x0, z0) * (65536 - fx) + corner_height(x0 + 1, z0) * fx;
        r1 = corner_height(x0, z0 + 1) * (65536 - fx)
           + corner_height(x0 + 1, z0 + 1) * fx;
        acc = r0 * (65536 - fz) + r1 * fz;
        h = (acc + (longint'(1) << 31)) >>> 32;
        if (h > 32767)
            h = 32767;
        if (h < -32768)
            h = -32768;
        res.height   = h[HEIGHT_W-1:0];
        res.in_range = 1'b1;
        return res;
    endfunction

    function automatic t_grid_op mk_write(int x, int z, int h);
        t_grid_op op;
        op.mode   = MODE_WRITE;
        op.cell_x = x[CELL_W-1:0];
        op.cell_z = z[CELL_W-1:0];
        op.height = h[HEIGHT_W-1:0];
        op.qx     = QUERY_W'($urandom);
        op.qz     = QUERY_W'($urandom);
        return op;
    endfunction

    function automatic t_grid_op mk_sample(int qx, int qz);
        t_grid_op op;
        op.mode   = MODE_SAMPLE;
        op.cell_x = CELL_W'($urandom);
        op.cell_z = CELL_W'($urandom);
        op.height = HEIGHT_W'($urandom);
        op.qx     = qx[QUERY_W-1:0];
        op.qz     = qz[QUERY_W-1:0];
        return op;
    endfunction

    // world coordinate that lands near or inside the active grid
    function automatic logic signed [QUERY_W-1:0] aim_coord(int size);
        longint pt, q;
        if (cfg_inv == 0)
            return QUERY_W'($urandom);
        pt = longint'($urandom_range(0, (size + 1) * 65536)) - 65536;
        q = pt / longint'(cfg_inv);
        if (q > 8388607)
            q = 8388607;
        if (q < -8388608)
            q = -8388608;
        return q[QUERY_W-1:0];
    endfunction

    function automatic t_grid_op rand_op();
        t_grid_op op;
        int r, lim_w, lim_d;
        op = mk_sample($urandom, $urandom);
        lim_w = (cfg_w == 0) ? 1 : ((cfg_w > GRID_MAX_W) ? GRID_MAX_W : int'(cfg_w));
        lim_d = (cfg_d == 0) ? 1 : ((cfg_d > GRID_MAX_D) ? GRID_MAX_D : int'(cfg_d));
        r = $urandom_range(0, 99);
        if (r < 35) begin
            op.mode = MODE_WRITE;
            if (r < 28) begin
                op.cell_x = CELL_W'($urandom_range(0, lim_w - 1));
                op.cell_z = CELL_W'($urandom_range(0, lim_d - 1));
            end
            if (r < 4)
                op.height = 16'sh7fff;
            else if (r < 8)
                op.height = 16'sh8000;
        end else if (r < 88) begin
            op.qx = aim_coord(int'(cfg_w));
            op.qz = aim_coord(int'(cfg_d));
        end
        return op;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap_left = 0;
        end else begin
            tx_valid_nxt = s_tvalid;
            if (s_tvalid && s_tready) begin
                res_tmp = apply_grid_op(cur_op);
                expected_heights.push_back(res_tmp);
                tx_valid_nxt = 1'b0;
                tx_gap_left = pick_gap(tx_idle_en);
            end
            if (!tx_valid_nxt) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                end else if (op_q.size() != 0) begin
                    cur_op = op_q.pop_front();
                    s_tdata <= {2'b00, cur_op.qz, cur_op.qx, cur_op.height,
                                cur_op.cell_z, cur_op.cell_x};
                    s_tuser <= cur_op.mode;
                    tx_valid_nxt = 1'b1;
                end
            end
            s_tvalid <= tx_valid_nxt;
        end
    end

    // output backpressure, including the long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_stall_left = 0;
            rx_hold_left = 0;
        end else if (holds_done != hold_reqs) begin
            holds_done++;
            rx_hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_stall_left = pick_gap(rx_idle_en);
        end
    end

    task automatic report_mismatch(string field, int exp_v, int got_v);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                     field, cyc_count, exp_v, got_v);
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_heights.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result at cycle %0d: height %0d in_range %0b",
                             cyc_count, $signed(m_tdata), m_tuser);
            end else begin
                res_exp = expected_heights.pop_front();
                if (m_tdata !== res_exp.height)
                    report_mismatch("height_out", int'($signed(res_exp.height)),
                                    int'($signed(m_tdata)));
                if (m_tuser !== res_exp.in_range)
                    report_mismatch("in_range", int'(res_exp.in_range), int'(m_tuser));
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_count++;
        if (cyc_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc_count);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // checked away from the rising edge so the driver and monitor have settled
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (op_q.size() != 0 || s_tvalid || expected_heights.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_WIDTH: cfg_w = val[7:0];
            REG_GRID_DEPTH: cfg_d = val[7:0];
            REG_INV_SCALE:  cfg_inv = val;
            default: ;
        endcase
    endtask

    task automatic run_phase(int w, int d, int inv, int n, bit tx_idle, bit rx_idle,
                             bit long_hold);
        wait_idle();
        write_reg(REG_GRID_WIDTH, 16'(w));
        write_reg(REG_GRID_DEPTH, 16'(d));
        write_reg(REG_INV_SCALE, 16'(inv));
        tx_idle_en = tx_idle;
        rx_idle_en = rx_idle;
        repeat (n)
            op_q.push_back(rand_op());
        if (long_hold)
            hold_reqs++;
    endtask

    initial begin
        for (int i = 0; i < GRID_MAX_W*GRID_MAX_D; i++)
            grid_mirror[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: 128 x 128 cells, one cell per world unit
        op_q.push_back(mk_write(0, 0, 32767));
        op_q.push_back(mk_write(1, 0, -32768));
        op_q.push_back(mk_write(0, 1, 'h1234));
        op_q.push_back(mk_write(1, 1, -1));
        op_q.push_back(mk_write(127, 127, -32768));
        op_q.push_back(mk_write(126, 127, 32767));
        op_q.push_back(mk_write(127, 126, 'h0100));
        op_q.push_back(mk_write(126, 126, -'h0100));
        op_q.push_back(mk_sample(0, 0));
        op_q.push_back(mk_sample(128, 128));
        op_q.push_back(mk_sample(64, 192));
        op_q.push_back(mk_sample(-128, 0));        // small negative: floor corner at -1
        op_q.push_back(mk_sample(0, -1));
        op_q.push_back(mk_sample(-256, 0));        // exactly -1.0 fails
        op_q.push_back(mk_sample(126*256 + 128, 126*256 + 128));
        op_q.push_back(mk_sample(127*256 - 1, 127*256 - 1));
        op_q.push_back(mk_sample(127*256, 0));     // last row/column fails
        op_q.push_back(mk_sample(0, 127*256));
        op_q.push_back(mk_sample(8388607, 8388607));
        op_q.push_back(mk_sample(-8388608, 8388607));
        op_q.push_back(mk_sample(8388607, -8388608));
        op_q.push_back(mk_write(127, 0, 'h5a5a));
        op_q.push_back(mk_sample(126*256 + 200, 40));

        run_phase(128, 128, 256, 150, 1'b1, 1'b1, 1'b0);
        run_phase(0, 5, 256, 60, 1'b1, 1'b1, 1'b0);       // zero width
        run_phase(1, 1, 1, 60, 1'b1, 1'b0, 1'b0);         // size one
        run_phase(2, 2, 65535, 80, 1'b0, 1'b1, 1'b0);
        run_phase(255, 255, 128, 150, 1'b1, 1'b1, 1'b0);  // beyond the store
        run_phase(16, 8, 0, 80, 1'b1, 1'b1, 1'b0);        // zero scale
        run_phase($urandom_range(1, 128), $urandom_range(1, 128),
                  $urandom_range(1, 65535), 200, 1'b0, 1'b0, 1'b1);
        run_phase(128, 128, 65535, 80, 1'b1, 1'b1, 1'b0);
        run_phase($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 65535), 200, 1'b1, 1'b1, 1'b0);
        run_phase(8, 8, 512, 140, 1'b1, 1'b1, 1'b1);

        wait_idle();
        if (n_errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/hbs_pkg.sv
sv/hbs_grid_ram.sv
sv/heightmap_bilinear_sampler_core.sv
sv/hbs_checker.sv
sim/tb_top.sv
